// ----- hw/rtl/pctfg_pkg.sv -----
// shared types and constants for the paced can test frame generator
`timescale 1ns / 1ps
`default_nettype none

package pctfg_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_SLOW_MODE  = 3'd1;
    localparam logic [2:0] REG_MIN_GAP    = 3'd2;
    localparam logic [2:0] REG_FRAME_RATE = 3'd3;
    localparam logic [2:0] REG_LOCKED_ID  = 3'd4;
    localparam logic [2:0] REG_EXT_MODE   = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // frame rate interval is FPS_DIVIDEND / frame rate
    localparam int          DIV_W        = 20;
    localparam int          DIV_CNT_W    = $clog2(DIV_W);
    localparam logic [19:0] FPS_DIVIDEND = 20'd1000000;
    localparam int          DIVISOR_W    = 32;

    // frame constants
    localparam logic [3:0]  DATA_LENGTH  = 4'd8;
    localparam logic [31:0] PAYLOAD_TAIL = 32'h7766_5544;
    localparam logic [28:0] EXT_ID_BIT   = 29'h100;

    // tdata layout widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 104;

    // pacing rule chosen for one poll
    typedef enum logic [1:0] {
        MODE_PERIOD,
        MODE_DELAY,
        MODE_FPS,
        MODE_FREE
    } pace_mode_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/paced_can_test_frame_generator_unit.sv -----
// top level of the paced can test frame generator
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is a poll carrying the microsecond time and the transmitter's
// ready flag; while enabled, a poll that the pacing rule lets through yields one
// frame beat, and a poll that it holds back (or any poll while disabled) yields
// nothing. A poll while disabled is taken and dropped, so the next beat can follow
// in the next cycle. An enabled poll goes from acceptance through the elapsed-time
// subtract, then the threshold compare together with loading the output register,
// and back to idle, which takes the next beat. With no minimum gap, slow mode off
// and a nonzero frame rate the interval comes from the restoring divider, 20 quotient
// bits at one per cycle, and the compare waits for its done flag.
// s_tready is low while a poll is in work, and the output stage waits for
// m_tready when the previous frame beat has not been taken yet.
module paced_can_test_frame_generator_unit #(
    parameter int unsigned ID_CYCLE       = 10,
    parameter int unsigned SLOW_PERIOD_US = 3000000
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [pctfg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pctfg_pkg::CFG_DATA_W-1:0]    cfg_data,
    // poll beats
    input  wire logic                                s_tvalid,
    output wire logic                                s_tready,
    // now_us[63:0], tx_ready[64], zero pad
    input  wire logic [pctfg_pkg::S_TDATA_W-1:0]     s_tdata,
    // frame beats
    output wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    // frame_id[28:0], data_length[32:29], payload[96:33], delivered[97], zero pad
    output wire logic [pctfg_pkg::M_TDATA_W-1:0]     m_tdata,
    // extended_frame[0]
    output wire logic                                m_tuser
);
    import pctfg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUB  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_CMP  = 4'b1000
    } state_t;

    // emit is folded into compare: a passing poll waits in compare for the output slot
    state_t state_reg, state_next;

    // configuration registers
    logic        enable_reg;
    logic        slow_mode_reg;
    logic [31:0] min_gap_reg;
    logic [31:0] frame_rate_reg;
    logic [29:0] locked_id_reg;
    logic        ext_mode_reg;

    // generator state
    logic [31:0] sent_count_reg, sent_count_next;
    logic [3:0]  cycle_id_reg,   cycle_id_next;
    logic [63:0] last_send_reg,  last_send_next;
    logic [63:0] last_slow_reg,  last_slow_next;

    // captured poll and working values
    logic [63:0] now_reg,     now_next;
    logic        ready_reg,   ready_next;
    pace_mode_t  mode_reg,    mode_next;
    logic [63:0] elapsed_reg, elapsed_next;
    logic        pass_reg,    pass_next;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;
    logic                 m_tuser_reg,  m_tuser_next;

    div_stat_t   div_stat;
    logic        div_start;
    logic [63:0] thresh;
    logic [63:0] base;
    logic [28:0] frame_id;
    logic        locked_neg;
    logic [4:0]  cycle_inc;
    logic        slot_free;

    pctfg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (frame_rate_reg),
        .stat    (div_stat)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            slow_mode_reg  <= 1'b0;
            min_gap_reg    <= '0;
            frame_rate_reg <= '0;
            locked_id_reg  <= '1;
            ext_mode_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ENABLE:     enable_reg     <= cfg_data[0];
                REG_SLOW_MODE:  slow_mode_reg  <= cfg_data[0];
                REG_MIN_GAP:    min_gap_reg    <= cfg_data;
                REG_FRAME_RATE: frame_rate_reg <= cfg_data;
                REG_LOCKED_ID:  locked_id_reg  <= cfg_data[29:0];
                REG_EXT_MODE:   ext_mode_reg   <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // frame fields
    assign locked_neg = locked_id_reg[29];
    assign cycle_inc  = {1'b0, cycle_id_reg} + 5'd1;
    always_comb begin
        frame_id = locked_neg ? {25'd0, cycle_id_reg} : locked_id_reg[28:0];
        if (ext_mode_reg) begin
            frame_id = frame_id | EXT_ID_BIT;
        end
    end

    // reference time and threshold of the chosen rule
    always_comb begin
        base   = (mode_reg == MODE_PERIOD) ? last_slow_reg : last_send_reg;
        unique case (mode_reg)
            MODE_PERIOD: thresh = 64'(SLOW_PERIOD_US);
            MODE_DELAY:  thresh = {32'd0, min_gap_reg};
            MODE_FPS:    thresh = {{(64 - DIV_W){1'b0}}, div_stat.quot};
            default:     thresh = '0;
        endcase
    end

    assign div_start = (state_reg == ST_SUB) && (mode_reg == MODE_FPS);
    assign slot_free = !m_tvalid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        now_next        = now_reg;
        ready_next      = ready_reg;
        mode_next       = mode_reg;
        elapsed_next    = elapsed_reg;
        pass_next       = pass_reg;
        sent_count_next = sent_count_reg;
        cycle_id_next   = cycle_id_reg;
        last_send_next  = last_send_reg;
        last_slow_next  = last_slow_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && enable_reg) begin
                    now_next   = s_tdata[63:0];
                    ready_next = s_tdata[64];
                    priority if (slow_mode_reg) begin
                        mode_next = MODE_PERIOD;
                    end else if (min_gap_reg != '0) begin
                        mode_next = MODE_DELAY;
                    end else if (frame_rate_reg != '0) begin
                        mode_next = MODE_FPS;
                    end else begin
                        mode_next = MODE_FREE;
                    end
                    state_next = ST_SUB;
                end
            end
            ST_SUB: begin
                elapsed_next = now_reg - base;
                state_next   = (mode_reg == MODE_FPS) ? ST_DIV : ST_CMP;
                pass_next    = 1'b0;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if ((mode_reg != MODE_FREE) && (elapsed_reg < thresh) && !pass_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    // passed; hold here until the output slot frees
                    pass_next = 1'b1;
                    if (slot_free) begin
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = ext_mode_reg;
                        m_tdata_next  = {6'd0, ready_reg, PAYLOAD_TAIL, sent_count_reg,
                                         DATA_LENGTH, frame_id};
                        if (mode_reg == MODE_PERIOD) begin
                            last_slow_next = now_reg;
                        end
                        if (ready_reg) begin
                            sent_count_next = sent_count_reg + 32'd1;
                            last_send_next  = now_reg;
                            if (locked_neg) begin
                                cycle_id_next = (cycle_inc == 5'(ID_CYCLE)) ? 4'd0
                                                                             : cycle_inc[3:0];
                            end
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            sent_count_reg <= '0;
            cycle_id_reg   <= '0;
            last_send_reg  <= '0;
            last_slow_reg  <= '0;
            pass_reg       <= 1'b0;
            mode_reg       <= MODE_FREE;
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            sent_count_reg <= sent_count_next;
            cycle_id_reg   <= cycle_id_next;
            last_send_reg  <= last_send_next;
            last_slow_reg  <= last_slow_next;
            pass_reg       <= pass_next;
            mode_reg       <= mode_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        ready_reg   <= ready_next;
        elapsed_reg <= elapsed_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pctfg_div.sv -----
// iterative restoring divider for the frame rate interval, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module pctfg_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [pctfg_pkg::DIVISOR_W-1:0] divisor,
    output pctfg_pkg::div_stat_t               stat
);
    import pctfg_pkg::*;

    logic [DIVISOR_W-1:0] rem_reg,  rem_next;
    logic [DIVISOR_W-1:0] dvs_reg,  dvs_next;
    logic [DIV_W-1:0]     quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    // one shift and trial subtract per cycle
    always_comb begin
        trial     = {rem_reg, quot_reg[DIV_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvs_next  = divisor;
            quot_next = FPS_DIVIDEND;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = DIVISOR_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
            end
            quot_next = {quot_reg[DIV_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb_paced_can_test_frame_generator_unit.sv -----
// self-checking testbench for the paced can test frame generator
`timescale 1ns / 1ps

module tb_paced_can_test_frame_generator_unit;
    import pctfg_pkg::*;

    // frame contents and pacing as the generator defines them
    localparam logic [3:0]  FRAME_DLC     = 4'd8;
    localparam logic [31:0] FRAME_TAIL    = 32'h7766_5544;
    localparam logic [28:0] EXT_FLAG_ID   = 29'h100;
    localparam logic [63:0] SLOW_GAP_US   = 64'd3000000;
    localparam logic [63:0] FPS_BASE_US   = 64'd1000000;
    localparam logic [3:0]  ID_WRAP       = 4'd9;

    // run control
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 225;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic [28:0] frame_id;
        logic        ext;
        logic [3:0]  dlc;
        logic [63:0] payload;
        logic        delivered;
    } can_frame_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_POLL_NONE,
        ROW_POLL_FRAME,
        ROW_POLL_PRED
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [31:0]           val;
        logic [63:0]           now;
        logic                  rdy;
        logic [28:0]           id;
        logic                  ext;
        logic [31:0]           cnt;
    } stim_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_W-1:0]      s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_TDATA_W-1:0]      m_tdata;
    logic                      m_tuser;

    // shadow registers and generator state
    logic        cfg_enable;
    logic        cfg_slow;
    logic [31:0] cfg_delay;
    logic [31:0] cfg_fps;
    logic [29:0] cfg_locked;
    logic        cfg_ext;
    logic [31:0] sent_frames;
    logic [3:0]  cycle_idx;
    logic [63:0] last_send_us;
    logic [63:0] last_period_us;

    can_frame_t  pending_frames[$];
    stim_row_t   stim_rows[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;

    paced_can_test_frame_generator_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // one poll through the pacing rules; returns 1 when a frame is attempted
    function automatic bit predict_frame(input logic [63:0] now, input logic rdy,
                                         output can_frame_t fr);
        logic [63:0] interval;
        logic [28:0] id;
        fr = '0;
        if (!cfg_enable)
            return 1'b0;
        if (cfg_slow) begin
            if (now - last_period_us < SLOW_GAP_US)
                return 1'b0;
            last_period_us = now;
        end else if (cfg_delay != 32'd0) begin
            if (now - last_send_us < {32'd0, cfg_delay})
                return 1'b0;
        end else if (cfg_fps != 32'd0) begin
            interval = FPS_BASE_US / {32'd0, cfg_fps};
            if (now - last_send_us < interval)
                return 1'b0;
        end
        // negative locked id selects the cycling identifier
        id = cfg_locked[29] ? {25'd0, cycle_idx} : cfg_locked[28:0];
        if (cfg_ext)
            id = id | EXT_FLAG_ID;
        fr.frame_id  = id;
        fr.ext       = cfg_ext;
        fr.dlc       = FRAME_DLC;
        fr.payload   = {FRAME_TAIL, sent_frames};
        fr.delivered = rdy;
        if (rdy) begin
            sent_frames  = sent_frames + 32'd1;
            last_send_us = now;
            if (cfg_locked[29])
                cycle_idx = (cycle_idx == ID_WRAP) ? 4'd0 : cycle_idx + 4'd1;
        end
        return 1'b1;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [31:0] val);
        stim_row_t r;
        r      = '{kind: ROW_CFG, default: '0};
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic stim_row_t poll_row(input row_kind_t kind, input logic [63:0] now,
                                           input logic rdy, input logic [28:0] id,
                                           input logic ext, input logic [31:0] cnt);
        stim_row_t r;
        r      = '{kind: kind, default: '0};
        r.now  = now;
        r.rdy  = rdy;
        r.id   = id;
        r.ext  = ext;
        r.cnt  = cnt;
        return r;
    endfunction

    // register write, mirrored into the shadow copy
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_ENABLE:     cfg_enable = val[0];
            REG_SLOW_MODE:  cfg_slow   = val[0];
            REG_MIN_GAP:    cfg_delay  = val;
            REG_FRAME_RATE: cfg_fps    = val;
            REG_LOCKED_ID:  cfg_locked = val[29:0];
            REG_EXT_MODE:   cfg_ext    = val[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // sender pause until every expected frame has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_frames.size() != 0);
    endtask

    // idle long enough for a poll without a frame to finish
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // offer one poll beat, predict on acceptance, then maybe go idle
    task automatic send_poll(input logic [63:0] now, input logic rdy,
                             input bit use_typed, input bit typed_has,
                             input can_frame_t typed_fr);
        can_frame_t fr;
        bit         has;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, rdy, now};
        do @(posedge aclk); while (!s_tready);
        has = predict_frame(now, rdy, fr);
        if (use_typed) begin
            has = typed_has;
            fr  = typed_fr;
        end
        if (has)
            pending_frames.push_back(fr);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end else begin
            burst_left--;
        end
    endtask

    // receiver: stretches of always-ready, coin-flip and mostly-stalled, plus a long hold on request
    initial begin : receiver
        int mode;
        int len;
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(10, 150);
            repeat (len) begin
                @(posedge aclk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // frame beat checker
    always @(posedge aclk) begin
        can_frame_t want;
        if (m_tvalid && m_tready) begin
            if (pending_frames.size() == 0) begin
                $error("frame beat with nothing expected: tdata %0h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_frames.pop_front();
                if (m_tdata[28:0] !== want.frame_id) begin
                    $error("frame_id: expected %0h, actual %0h", want.frame_id, m_tdata[28:0]);
                    mismatch_count++;
                end
                if (m_tuser !== want.ext) begin
                    $error("extended_frame: expected %0h, actual %0h", want.ext, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[32:29] !== want.dlc) begin
                    $error("data_length: expected %0h, actual %0h", want.dlc, m_tdata[32:29]);
                    mismatch_count++;
                end
                if (m_tdata[96:33] !== want.payload) begin
                    $error("payload: expected %0h, actual %0h", want.payload, m_tdata[96:33]);
                    mismatch_count++;
                end
                if (m_tdata[97] !== want.delivered) begin
                    $error("delivered: expected %0h, actual %0h", want.delivered, m_tdata[97]);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        can_frame_t  typed_fr;
        logic [63:0] clock_us;
        logic [63:0] gap_us;
        logic [63:0] step_us;
        logic [31:0] val;
        int          counted;
        int          target;

        // reset values of the shadow copy
        cfg_enable     = 1'b0;
        cfg_slow       = 1'b0;
        cfg_delay      = 32'd0;
        cfg_fps        = 32'd0;
        cfg_locked     = 30'h3FFF_FFFF;
        cfg_ext        = 1'b0;
        sent_frames    = 32'd0;
        cycle_idx      = 4'd0;
        last_send_us   = 64'd0;
        last_period_us = 64'd0;

        // directed rows: disabled, unpaced, id forms, delay, frame rate, slow mode
        stim_rows.push_back(poll_row(ROW_POLL_NONE, 64'd0, 1'b1, 29'd0, 1'b0, 32'd0));
        stim_rows.push_back(cfg_row(REG_ENABLE, 32'd1));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, 64'd0, 1'b0, 29'd0, 1'b0, 32'd0));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, 64'd5, 1'b1, 29'd0, 1'b0, 32'd0));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, '1, 1'b1, 29'd1, 1'b0, 32'd1));
        stim_rows.push_back(cfg_row(REG_EXT_MODE, 32'd1));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, 64'd0, 1'b1, 29'h102, 1'b1, 32'd2));
        stim_rows.push_back(cfg_row(REG_LOCKED_ID, 32'h1FFF_FFFF));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, 64'd1, 1'b1, 29'h1FFF_FFFF, 1'b1, 32'd3));
        stim_rows.push_back(cfg_row(REG_LOCKED_ID, 32'd0));
        stim_rows.push_back(cfg_row(REG_EXT_MODE, 32'd0));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, 64'd2, 1'b1, 29'd0, 1'b0, 32'd4));
        // most negative locked id still cycles
        stim_rows.push_back(cfg_row(REG_LOCKED_ID, 32'hE000_0000));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, 64'd3, 1'b1, 29'd3, 1'b0, 32'd5));
        stim_rows.push_back(cfg_row(REG_MIN_GAP, 32'd100));
        stim_rows.push_back(poll_row(ROW_POLL_NONE, 64'd50, 1'b1, 29'd0, 1'b0, 32'd0));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, 64'd103, 1'b0, 29'd4, 1'b0, 32'd6));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, 64'd103, 1'b1, 29'd4, 1'b0, 32'd6));
        stim_rows.push_back(cfg_row(REG_MIN_GAP, 32'hFFFF_FFFF));
        stim_rows.push_back(poll_row(ROW_POLL_NONE, 64'd104, 1'b1, 29'd0, 1'b0, 32'd0));
        // time going backward wraps to a huge elapsed value
        stim_rows.push_back(poll_row(ROW_POLL_PRED, 64'd102, 1'b1, 29'd0, 1'b0, 32'd0));
        stim_rows.push_back(cfg_row(REG_MIN_GAP, 32'd0));
        stim_rows.push_back(cfg_row(REG_FRAME_RATE, 32'd1000001));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, 64'd102, 1'b1, 29'd6, 1'b0, 32'd8));
        stim_rows.push_back(cfg_row(REG_FRAME_RATE, 32'hFFFF_FFFF));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, 64'd102, 1'b1, 29'd7, 1'b0, 32'd9));
        stim_rows.push_back(cfg_row(REG_FRAME_RATE, 32'd1));
        stim_rows.push_back(poll_row(ROW_POLL_NONE, 64'd1000101, 1'b1, 29'd0, 1'b0, 32'd0));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, 64'd1000102, 1'b1, 29'd8, 1'b0, 32'd10));
        stim_rows.push_back(cfg_row(REG_FRAME_RATE, 32'd3));
        stim_rows.push_back(poll_row(ROW_POLL_PRED, 64'd1333435, 1'b1, 29'd0, 1'b0, 32'd0));
        stim_rows.push_back(poll_row(ROW_POLL_PRED, 64'd1333436, 1'b1, 29'd0, 1'b0, 32'd0));
        // slow mode period restarts even when the frame is refused
        stim_rows.push_back(cfg_row(REG_SLOW_MODE, 32'd1));
        stim_rows.push_back(poll_row(ROW_POLL_NONE, 64'd2999999, 1'b0, 29'd0, 1'b0, 32'd0));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, 64'd3000000, 1'b0, 29'd0, 1'b0, 32'd12));
        stim_rows.push_back(poll_row(ROW_POLL_NONE, 64'd3000001, 1'b1, 29'd0, 1'b0, 32'd0));
        stim_rows.push_back(poll_row(ROW_POLL_FRAME, 64'd6000000, 1'b1, 29'd0, 1'b0, 32'd12));
        stim_rows.push_back(cfg_row(REG_ENABLE, 32'd0));
        stim_rows.push_back(poll_row(ROW_POLL_NONE, 64'd6000000, 1'b1, 29'd0, 1'b0, 32'd0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed rows
        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG) begin
                settle();
                cfg_write(stim_rows[i].idx, stim_rows[i].val);
            end else begin
                typed_fr.frame_id  = stim_rows[i].id;
                typed_fr.ext       = stim_rows[i].ext;
                typed_fr.dlc       = FRAME_DLC;
                typed_fr.payload   = {FRAME_TAIL, stim_rows[i].cnt};
                typed_fr.delivered = stim_rows[i].rdy;
                send_poll(stim_rows[i].now, stim_rows[i].rdy,
                          stim_rows[i].kind != ROW_POLL_PRED,
                          stim_rows[i].kind == ROW_POLL_FRAME, typed_fr);
            end
        end

        // random phases, each under a fresh register setting
        clock_us = {$urandom, $urandom};
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            cfg_write(REG_SLOW_MODE, 32'($urandom_range(0, 4) == 0));
            case ($urandom_range(0, 5))
                0, 1, 2: val = 32'd0;
                3:       val = $urandom_range(1, 5000);
                4:       val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            cfg_write(REG_MIN_GAP, val);
            case ($urandom_range(0, 6))
                0:       val = 32'd0;
                1:       val = 32'd1;
                2:       val = 32'd1000000;
                3:       val = 32'd1000001;
                4:       val = 32'hFFFF_FFFF;
                5:       val = $urandom_range(1, 100000);
                default: val = $urandom;
            endcase
            cfg_write(REG_FRAME_RATE, val);
            case ($urandom_range(0, 3))
                0:       val = 32'hFFFF_FFFF;
                1:       val = {3'b111, 29'($urandom)};
                2:       val = {3'b000, 29'($urandom)};
                default: val = ($urandom_range(0, 1) == 1) ? 32'h1FFF_FFFF : 32'd0;
            endcase
            cfg_write(REG_LOCKED_ID, val);
            cfg_write(REG_EXT_MODE, $urandom_range(0, 1));
            cfg_write(REG_ENABLE, 32'((p == 0) || ($urandom_range(0, 6) != 0)));

            // typical pacing gap drives the time steps
            if (cfg_slow)
                gap_us = SLOW_GAP_US;
            else if (cfg_delay != 32'd0)
                gap_us = {32'd0, cfg_delay};
            else if (cfg_fps != 32'd0)
                gap_us = FPS_BASE_US / {32'd0, cfg_fps};
            else
                gap_us = 64'd16;
            if ($urandom_range(0, 1) == 1)
                clock_us = {$urandom, $urandom};

            // a disabled generator ignores polls, so keep that phase short
            target = cfg_enable ? PHASE_ITEMS : 30;
            counted = 0;
            while (counted < target) begin
                if (counted == target / 3)
                    hold_req = 1'b1;
                if (counted == (2 * target) / 3)
                    wait_drained();
                if ($urandom_range(0, 19) == 0) begin
                    clock_us = {$urandom, $urandom};
                end else begin
                    step_us  = {$urandom, $urandom} % (2 * gap_us + 64'd2);
                    clock_us = clock_us + step_us;
                end
                send_poll(clock_us, ($urandom_range(0, 3) != 0), 1'b0, 1'b0, typed_fr);
                counted++;
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
